/* rtl/core/tti_pkg.sv */
// ----------------------------------------------------------------------------
// Trilinear table interpolator package
// Shared sizes, types and arithmetic helpers.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int unsigned TableSide  = 32;
  localparam int unsigned TableEdge  = TableSide + 1;
  localparam int unsigned TableDepth = TableEdge * TableEdge * TableEdge;
  localparam int unsigned IdxW       = $clog2(TableSide);
  localparam int unsigned BankIdxW   = $clog2((TableEdge + 1) / 2);
  localparam int unsigned BankDepth  = ((TableEdge + 1) / 2) ** 3;
  localparam int unsigned BankAddrW  = $clog2(BankDepth);
  localparam int unsigned NumTables  = 4;
  localparam int unsigned CoordLimit = TableEdge << 16;
  localparam logic [31:0] ScaleReset = 32'h0040_0000;

  // Division of a 16-bit value by TableEdge as a multiply and a shift.
  localparam int unsigned RecipShift = 16 + $clog2(TableEdge);
  localparam int unsigned RecipMult  = ((1 << RecipShift) + TableEdge - 1) / TableEdge;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef logic signed [31:0] word_t;
  typedef logic signed [49:0] acc_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [17:0]     wt;
  } axis_t;

  typedef struct packed {
    logic  command;
    logic [15:0] entry_index;
    word_t force_x_entry;
    word_t force_y_entry;
    word_t force_z_entry;
    word_t potential_entry;
    word_t offset_x;
    word_t offset_y;
    word_t offset_z;
  } in_word_t;

  typedef struct packed {
    word_t corr_force_x;
    word_t corr_force_y;
    word_t corr_force_z;
    word_t corr_potential;
  } out_word_t;

  // Divide by 2^16 rounding half toward plus infinity.
  function automatic acc_t rnd16(input logic signed [67:0] x);
    logic signed [67:0] t;
    t = x + 68'sd32768;
    return acc_t'(t >>> 16);
  endfunction

  function automatic word_t sat32(input acc_t x);
    if (x > acc_t'(64'sd2147483647)) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -acc_t'(64'sd2147483648)) begin
      return 32'sh8000_0000;
    end
    return word_t'(x);
  endfunction

endpackage

/* rtl/core/tti_if.sv */
// ----------------------------------------------------------------------------
// Trilinear table interpolator channel
// Valid/ready channel that carries one word of type T.
// ----------------------------------------------------------------------------
interface tti_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/tti_cfg_if.sv */
// ----------------------------------------------------------------------------
// Trilinear table interpolator configuration channel
// Valid/ready write channel for the scale register.
// ----------------------------------------------------------------------------
interface tti_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/trilinear_table_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// Trilinear table interpolator
// Eight-bank corner tables and a pipelined trilinear blend.
// ----------------------------------------------------------------------------
// One word enters every cycle while the pipeline advances. A query's result
// passes through the scale multiply, the index stage, the corner memory read
// and three blend stages; the whole pipeline advances only when its last stage
// is empty or being taken, so a stall holds every word in place. Writes give
// no result and pass through the same stages, reaching the tables at the stage
// where queries read them.
module trilinear_table_interpolator_unit (
  input  logic clk_i,
  input  logic rst_ni,
  tti_cfg_if.sink cfg,
  tti_if.sink     in_ch,
  tti_if.source   out_ch
);
  import tti_pkg::*;

  localparam int unsigned Stages = 6;

  logic [31:0]  scale_q;
  logic         vld_q [Stages];
  logic         adv;
  in_word_t     w;

  // Write decode, split the linear address into three coordinates,
  // one division by the table edge per stage.
  logic [15:0] wa;
  logic [39:0] wq_prod, wi_prod;
  logic [15:0] wq, wk, wi, wj;
  logic        wr_en;
  logic        wr0_q, wr1_q;
  logic [15:0] wq_q, wk0_q;
  logic [15:0] wi_q, wj_q, wk_q;
  word_t       wdat0_q [NumTables];
  word_t       wdat1_q [NumTables];

  assign w       = in_ch.data;
  assign adv     = !vld_q[Stages-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg.ready   = 1'b1;

  assign wa      = w.entry_index;
  assign wq_prod = 40'(wa) * 40'(RecipMult);
  assign wq      = 16'(wq_prod >> RecipShift);
  assign wk      = wa - 16'(wq * 16'(TableEdge));
  assign wi_prod = 40'(wq_q) * 40'(RecipMult);
  assign wi      = 16'(wi_prod >> RecipShift);
  assign wj      = wq_q - 16'(wi * 16'(TableEdge));
  assign wr_en   = in_ch.valid && (w.command == CMD_WRITE) && (32'(wa) < TableDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg.valid) begin
      scale_q <= cfg.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        vld_q[s] <= 1'b0;
      end
      wr0_q <= 1'b0;
      wr1_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_ch.valid && (w.command == CMD_QUERY);
      for (int s = 1; s < Stages; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      wr0_q <= wr_en;
      wr1_q <= wr0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wq_q       <= wq;
      wk0_q      <= wk;
      wdat0_q[0] <= w.force_x_entry;
      wdat0_q[1] <= w.force_y_entry;
      wdat0_q[2] <= w.force_z_entry;
      wdat0_q[3] <= w.potential_entry;
      wi_q       <= wi;
      wj_q       <= wj;
      wk_q       <= wk0_q;
      for (int t = 0; t < NumTables; t++) begin
        wdat1_q[t] <= wdat0_q[t];
      end
    end
  end

  // Axis mapping, stages 0 and 1.
  axis_t ax [3];
  logic  ng [3];
  word_t offs [3];
  assign offs[0] = w.offset_x;
  assign offs[1] = w.offset_y;
  assign offs[2] = w.offset_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    tti_axis_map u_map (
      .clk_i   (clk_i),
      .en_i    (adv),
      .offset_i(offs[a]),
      .scale_i (scale_q),
      .axis_o  (ax[a]),
      .neg_o   (ng[a])
    );
  end

  // Corner banks, selected by coordinate parity, read at stage 2.
  word_t rd [8][NumTables];
  logic [17:0] wt_q [3][3];
  logic        ng_q [3][4];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam int unsigned Pi = (b >> 2) & 1;
    localparam int unsigned Pj = (b >> 1) & 1;
    localparam int unsigned Pk = b & 1;
    word_t mem [BankDepth][NumTables];
    logic [BankIdxW-1:0] ri, rj, rk;
    logic [IdxW:0] ci, cj, ck;
    logic [BankAddrW-1:0] raddr, waddr;
    logic bank_wr;

    assign ci = ({1'b0, ax[0].idx} + (IdxW+1)'(1 - Pi + ax[0].idx[0])) ;
    assign cj = ({1'b0, ax[1].idx} + (IdxW+1)'(1 - Pj + ax[1].idx[0]));
    assign ck = ({1'b0, ax[2].idx} + (IdxW+1)'(1 - Pk + ax[2].idx[0]));
    // Corner with parity P is idx or idx+1, whichever matches.
    assign ri = BankIdxW'((ax[0].idx[0] == Pi[0] ? {1'b0, ax[0].idx} : ci) >> 1);
    assign rj = BankIdxW'((ax[1].idx[0] == Pj[0] ? {1'b0, ax[1].idx} : cj) >> 1);
    assign rk = BankIdxW'((ax[2].idx[0] == Pk[0] ? {1'b0, ax[2].idx} : ck) >> 1);
    assign raddr = BankAddrW'((32'(ri) * ((TableEdge + 1) / 2) + 32'(rj))
                   * ((TableEdge + 1) / 2) + 32'(rk));
    assign waddr = BankAddrW'((32'(wi_q >> 1) * ((TableEdge + 1) / 2) + 32'(wj_q >> 1))
                   * ((TableEdge + 1) / 2) + 32'(wk_q >> 1));
    assign bank_wr = wr1_q && adv && (wi_q[0] == Pi[0]) && (wj_q[0] == Pj[0])
                     && (wk_q[0] == Pk[0]);

    always_ff @(posedge clk_i) begin
      if (bank_wr) begin
        for (int t = 0; t < NumTables; t++) begin
          mem[waddr][t] <= wdat1_q[t];
        end
      end
      if (adv) begin
        for (int t = 0; t < NumTables; t++) begin
          rd[b][t] <= mem[raddr][t];
        end
      end
    end
  end

  // Corner order of bank b depends on index parity, kept with the read.
  logic [2:0] par_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      par_q <= {ax[0].idx[0], ax[1].idx[0], ax[2].idx[0]};
      for (int a = 0; a < 3; a++) begin
        wt_q[a][0] <= ax[a].wt;
        ng_q[a][0] <= ng[a];
        for (int s = 1; s < 3; s++) begin
          wt_q[a][s] <= wt_q[a][s-1];
        end
        for (int s = 1; s < 4; s++) begin
          ng_q[a][s] <= ng_q[a][s-1];
        end
      end
    end
  end

  // Blend along z, then y, then x.
  acc_t za [16], zb [16], zy [16];
  acc_t ya [8],  yb [8],  yy [8];
  acc_t xa [4],  xb [4],  xy [4];

  always_comb begin
    for (int di = 0; di < 2; di++) begin
      for (int dj = 0; dj < 2; dj++) begin
        for (int t = 0; t < NumTables; t++) begin
          za[(di*2+dj)*4+t] = acc_t'(rd[{di[0] ^ par_q[2], dj[0] ^ par_q[1], par_q[0]}][t]);
          zb[(di*2+dj)*4+t] = acc_t'(rd[{di[0] ^ par_q[2], dj[0] ^ par_q[1], ~par_q[0]}][t]);
        end
      end
    end
    for (int di = 0; di < 2; di++) begin
      for (int t = 0; t < NumTables; t++) begin
        ya[di*4+t] = zy[(di*2)*4+t];
        yb[di*4+t] = zy[(di*2+1)*4+t];
      end
    end
    for (int t = 0; t < NumTables; t++) begin
      xa[t] = yy[t];
      xb[t] = yy[4+t];
    end
  end

  for (genvar n = 0; n < 16; n++) begin : g_lz
    tti_lerp u_lerp (.clk_i(clk_i), .en_i(adv), .a_i(za[n]), .b_i(zb[n]),
                     .t_i(wt_q[2][0]), .y_o(zy[n]));
  end
  for (genvar n = 0; n < 8; n++) begin : g_ly
    tti_lerp u_lerp (.clk_i(clk_i), .en_i(adv), .a_i(ya[n]), .b_i(yb[n]),
                     .t_i(wt_q[1][1]), .y_o(yy[n]));
  end
  for (genvar n = 0; n < 4; n++) begin : g_lx
    tti_lerp u_lerp (.clk_i(clk_i), .en_i(adv), .a_i(xa[n]), .b_i(xb[n]),
                     .t_i(wt_q[0][2]), .y_o(xy[n]));
  end

  out_word_t res;
  always_comb begin
    res.corr_force_x   = sat32(ng_q[0][3] ? xy[0] : -xy[0]);
    res.corr_force_y   = sat32(ng_q[1][3] ? xy[1] : -xy[1]);
    res.corr_force_z   = sat32(ng_q[2][3] ? xy[2] : -xy[2]);
    res.corr_potential = sat32(xy[3]);
  end

  assign out_ch.valid = vld_q[Stages-1];
  assign out_ch.data  = res;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped under stall");
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready && (w.command == CMD_WRITE) |=> !vld_q[0])
    else $error("result started for a write word");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("stalled with empty output");

endmodule

/* rtl/core/tti_axis_map.sv */
// ----------------------------------------------------------------------------
// Trilinear table interpolator axis mapper
// Two-stage offset to index and weight conversion for one axis.
// ----------------------------------------------------------------------------
module tti_axis_map (
  input  logic            clk_i,
  input  logic            en_i,
  input  tti_pkg::word_t  offset_i,
  input  logic [31:0]     scale_i,
  output tti_pkg::axis_t  axis_o,
  output logic            neg_o
);
  import tti_pkg::*;

  logic [63:0] prod_q;
  logic        neg_q;
  logic [31:0] mag;
  logic [47:0] coord;
  logic [47:0] idx_full;
  axis_t       axis_d;
  axis_t       axis_q;
  logic        neg2_q;

  assign mag = offset_i[31] ? (~offset_i + 32'd1) : offset_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= mag * scale_i;
      neg_q  <= offset_i[31];
      axis_q <= axis_d;
      neg2_q <= neg_q;
    end
  end

  always_comb begin
    coord = prod_q[63:16];
    if (coord > 48'(CoordLimit)) begin
      coord = 48'(CoordLimit);
    end
    idx_full = coord >> 16;
    if (idx_full >= 48'(TableSide)) begin
      idx_full = 48'(TableSide - 1);
    end
    axis_d.idx = idx_full[IdxW-1:0];
    axis_d.wt  = 18'(coord - (idx_full << 16));
  end

  assign axis_o = axis_q;
  assign neg_o  = neg2_q;

endmodule

/* rtl/core/tti_lerp.sv */
// ----------------------------------------------------------------------------
// Trilinear table interpolator blend step
// Registered linear step a + rnd((b - a) * t) for one lane.
// ----------------------------------------------------------------------------
module tti_lerp (
  input  logic              clk_i,
  input  logic              en_i,
  input  tti_pkg::acc_t     a_i,
  input  tti_pkg::acc_t     b_i,
  input  logic [17:0]       t_i,
  output tti_pkg::acc_t     y_o
);
  import tti_pkg::*;

  acc_t y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= a_i + rnd16(68'(b_i - a_i) * $signed({1'b0, t_i}));
    end
  end

  assign y_o = y_q;

endmodule

/* dv/trilinear_table_interpolator_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trilinear table interpolator unit test
// Loads the corner tables through write words and sends query words under
// several index scales, with random idling on both channels and one long
// receiver stall. Every query result is checked against a local model.
// ----------------------------------------------------------------------------
module trilinear_table_interpolator_unit_test;
  import tti_pkg::*;

  logic clk_i;
  logic rst_ni;

  tti_cfg_if             cfg_ch ();
  tti_if #(.T(in_word_t))  in_ch ();
  tti_if #(.T(out_word_t)) out_ch ();

  trilinear_table_interpolator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_word_t  pending_words[$];
  out_word_t expected_corr[$];

  word_t     model_tab[NumTables][TableDepth];
  bit        planned[TableDepth];
  logic [31:0] model_scale;
  logic [31:0] plan_scale;

  int  mismatches;
  int  pushed;
  bit  calm;
  bit  rx_hold;
  int  src_gap;
  int  dst_gap;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void map_axis(input word_t o, input logic [31:0] sc,
                                   output int idx, output longint wt, output bit neg);
    logic [63:0] mag;
    logic [63:0] c;
    neg = o[31];
    mag = {32'd0, neg ? 32'(-o) : 32'(o)};
    c = (mag * {32'd0, sc}) >> 16;
    if (c > 64'(CoordLimit)) c = 64'(CoordLimit);
    idx = int'(c >> 16);
    if (idx >= TableSide) idx = TableSide - 1;
    wt = longint'(c) - (longint'(idx) << 16);
  endfunction

  function automatic longint lerp_step(input longint a, input longint b, input longint t);
    longint p;
    p = (b - a) * t + 32768;
    return a + (p >>> 16);
  endfunction

  function automatic word_t clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return word_t'(x);
  endfunction

  function automatic int addr_of(input int i, input int j, input int k);
    return (i * TableEdge + j) * TableEdge + k;
  endfunction

  function automatic longint blend_table(input int n, input int i, input int j, input int k,
                                         input longint u, input longint v, input longint w);
    longint plane[2];
    longint row[2];
    for (int di = 0; di < 2; di++) begin
      for (int dj = 0; dj < 2; dj++) begin
        row[dj] = lerp_step(longint'(model_tab[n][addr_of(i + di, j + dj, k)]),
                            longint'(model_tab[n][addr_of(i + di, j + dj, k + 1)]), w);
      end
      plane[di] = lerp_step(row[0], row[1], v);
    end
    return lerp_step(plane[0], plane[1], u);
  endfunction

  function automatic void predict_word(input in_word_t wd);
    int i, j, k;
    longint u, v, w;
    bit nx, ny, nz;
    longint fx, fy, fz, pt;
    out_word_t r;
    if (wd.command == CMD_WRITE) begin
      if (wd.entry_index < TableDepth) begin
        model_tab[0][wd.entry_index] = wd.force_x_entry;
        model_tab[1][wd.entry_index] = wd.force_y_entry;
        model_tab[2][wd.entry_index] = wd.force_z_entry;
        model_tab[3][wd.entry_index] = wd.potential_entry;
      end
      return;
    end
    map_axis(wd.offset_x, model_scale, i, u, nx);
    map_axis(wd.offset_y, model_scale, j, v, ny);
    map_axis(wd.offset_z, model_scale, k, w, nz);
    fx = blend_table(0, i, j, k, u, v, w);
    fy = blend_table(1, i, j, k, u, v, w);
    fz = blend_table(2, i, j, k, u, v, w);
    pt = blend_table(3, i, j, k, u, v, w);
    r.corr_force_x   = clip32(nx ? fx : -fx);
    r.corr_force_y   = clip32(ny ? fy : -fy);
    r.corr_force_z   = clip32(nz ? fz : -fz);
    r.corr_potential = clip32(pt);
    expected_corr.push_back(r);
  endfunction

  function automatic word_t entry_value(input bit extreme);
    if (extreme) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return word_t'($urandom);
  endfunction

  function automatic void push_write(input int unsigned a, input bit extreme);
    in_word_t wd;
    wd.command         = CMD_WRITE;
    wd.entry_index     = a[15:0];
    wd.force_x_entry   = entry_value(extreme);
    wd.force_y_entry   = entry_value(extreme);
    wd.force_z_entry   = entry_value(extreme);
    wd.potential_entry = entry_value(extreme);
    wd.offset_x        = word_t'($urandom);
    wd.offset_y        = word_t'($urandom);
    wd.offset_z        = word_t'($urandom);
    if (a < TableDepth) planned[a] = 1'b1;
    pending_words.push_back(wd);
    pushed++;
  endfunction

  function automatic void push_query(input word_t ox, input word_t oy, input word_t oz,
                                     input bit extreme);
    int i, j, k;
    longint t;
    bit n;
    int a;
    in_word_t wd;
    map_axis(ox, plan_scale, i, t, n);
    map_axis(oy, plan_scale, j, t, n);
    map_axis(oz, plan_scale, k, t, n);
    for (int c = 0; c < 8; c++) begin
      a = addr_of(i + c[2], j + c[1], k + c[0]);
      if (!planned[a]) push_write(a, extreme);
    end
    wd.command         = CMD_QUERY;
    wd.entry_index     = 16'($urandom);
    wd.force_x_entry   = word_t'($urandom);
    wd.force_y_entry   = word_t'($urandom);
    wd.force_z_entry   = word_t'($urandom);
    wd.potential_entry = word_t'($urandom);
    wd.offset_x        = ox;
    wd.offset_y        = oy;
    wd.offset_z        = oz;
    pending_words.push_back(wd);
    pushed++;
  endfunction

  function automatic word_t rand_offset();
    logic [63:0] mag;
    logic [63:0] c;
    case ($urandom_range(0, 3))
      0: return word_t'($urandom);
      3: mag = 64'($urandom_range(0, 65535));
      default: begin
        c = 64'($urandom_range(0, (TableEdge + 1) << 16));
        mag = (plan_scale != 0) ? (c << 16) / plan_scale : 64'($urandom);
      end
    endcase
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    return $urandom_range(0, 1) ? word_t'(-mag[31:0]) : word_t'(mag[31:0]);
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_ch.valid || expected_corr.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_scale(input logic [31:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_scale = value;
    plan_scale  = value;
  endtask

  task automatic random_phase(input int budget);
    int stop;
    stop = pushed + budget;
    while (pushed < stop) begin
      case ($urandom_range(0, 19))
        0: push_write($urandom_range(TableDepth, 65535), 1'b0);
        1: push_write($urandom_range(0, TableDepth - 1), 1'b0);
        default: ;
      endcase
      push_query(rand_offset(), rand_offset(), rand_offset(), $urandom_range(0, 9) == 0);
    end
  endtask

  // Source side: offers pending words with random idle bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 16);
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_ch.data  <= pending_words.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Sink side: random idle bursts plus the long hold.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      dst_gap = 0;
    end else if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (dst_gap > 0) begin
      dst_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      dst_gap = $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    rx_hold = 1'b0;
    @(posedge rst_ni);
    do @(posedge clk_i); while (pending_words.size() < 60);
    rx_hold = 1'b1;
    repeat (250) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) predict_word(in_ch.data);
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_corr.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", out_ch.data);
      end else begin
        want = expected_corr.pop_front();
        if (out_ch.data.corr_force_x !== want.corr_force_x
            || out_ch.data.corr_force_y !== want.corr_force_y
            || out_ch.data.corr_force_z !== want.corr_force_z
            || out_ch.data.corr_potential !== want.corr_potential) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %h %h %h %h, got %h %h %h %h",
                     want.corr_force_x, want.corr_force_y, want.corr_force_z,
                     want.corr_potential, out_ch.data.corr_force_x,
                     out_ch.data.corr_force_y, out_ch.data.corr_force_z,
                     out_ch.data.corr_potential);
          end
        end
      end
    end
  end

  initial begin
    mismatches   = 0;
    pushed       = 0;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    model_scale  = ScaleReset;
    plan_scale   = ScaleReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_write(0, 1'b1);
    push_write(TableDepth - 1, 1'b1);
    push_write(16'hFFFF, 1'b0);
    push_write(TableDepth, 1'b0);
    push_query(32'sd0, 32'sd0, 32'sd0, 1'b0);
    push_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    push_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    push_query(-32'sd1, 32'sd1, -32'sd1, 1'b0);
    push_query(32'sh0000_8000, -32'sh0000_8000, 32'sh0007_C000, 1'b0);
    push_query(32'sh0008_4000, 32'sh0008_4000, -32'sh0008_4000, 1'b1);
    push_query(32'sh0000_0400, -32'sh0000_0400, 32'sh0000_0400, 1'b0);
    wait_idle();

    set_scale(32'h0000_0000);
    random_phase(60);
    wait_idle();
    set_scale(32'hFFFF_FFFF);
    random_phase(100);
    wait_idle();
    set_scale($urandom);
    random_phase(100);
    wait_idle();
    set_scale(32'h0001_0000);
    random_phase(100);
    wait_idle();
    set_scale(32'h0020_0000);
    random_phase(100);
    wait_idle();
    set_scale(ScaleReset);
    random_phase(100);
    wait_idle();
    calm = 1'b1;
    set_scale($urandom_range(32'h0001_0000, 32'h0100_0000));
    random_phase(90);
    wait_idle();

    if (mismatches == 0 && expected_corr.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tti_pkg.sv
rtl/core/tti_if.sv
rtl/core/tti_cfg_if.sv
rtl/core/tti_axis_map.sv
rtl/core/tti_lerp.sv
rtl/core/trilinear_table_interpolator_unit.sv
dv/trilinear_table_interpolator_unit_test.sv
